// File: design/mtc_pkg.sv
// package: shared types and constants of the multi-tap chorus
`timescale 1ns / 1ps
package mtc_pkg;

    // configuration register indexes
    localparam logic [2:0] CFG_BASE_DELAY = 3'd0;
    localparam logic [2:0] CFG_DEPTH      = 3'd1;
    localparam logic [2:0] CFG_PHASE_STEP = 3'd2;
    localparam logic [2:0] CFG_NUM_TAPS   = 3'd3;
    localparam logic [2:0] CFG_MIX        = 3'd4;
    localparam logic [2:0] CFG_STEREO     = 3'd5;

    // op codes of an input beat
    localparam logic OP_PROCESS = 1'b0;
    localparam logic OP_CLEAR   = 1'b1;

    // serial divider sizes: dividend up to tap index times 2^32, divisor up to 16
    localparam int DVD_W = 36;
    localparam int DVS_W = 5;

    // final mix accumulator
    localparam int ACC_W = 62;

    // quarter wave polynomial coefficients, q15
    localparam logic [32:0] SIN_C  = 33'd2320;
    localparam logic [16:0] SIN_B  = 17'd21024;
    localparam logic [16:0] SIN_A  = 17'd51472;
    localparam logic [16:0] Q15_ONE = 17'd32768;

    typedef enum logic [4:0] {
        ST_INIT,
        ST_IWAIT,
        ST_IDLE,
        ST_TAP,
        ST_SIN_A,
        ST_SIN_B,
        ST_SIN_C,
        ST_SIN_D,
        ST_DLY,
        ST_RDA,
        ST_RDB,
        ST_MB,
        ST_PAN,
        ST_PDIV,
        ST_PL,
        ST_PR,
        ST_MONO,
        ST_NEXT,
        ST_ADV,
        ST_MX1,
        ST_MX2,
        ST_CH1,
        ST_CH2,
        ST_CH3,
        ST_CH4,
        ST_DONE
    } t_state;

endpackage

// File: design/mtc_if.sv
// interfaces: sample input channel and mixed output channel
`timescale 1ns / 1ps
interface mtc_in_if;
    logic               valid;
    logic               ready;
    logic               op;
    logic signed [15:0] sample_in;

    modport source (output valid, output op, output sample_in, input ready);
    modport sink   (input valid, input op, input sample_in, output ready);
endinterface

interface mtc_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] left_out;
    logic signed [15:0] right_out;

    modport source (output valid, output left_out, output right_out, input ready);
    modport sink   (input valid, input left_out, input right_out, output ready);
endinterface

// File: design/multi_tap_chorus_top.sv
// top level: multi-tap chorus on one shared delay store, one shared multiplier
`timescale 1ns / 1ps
// usage
//   i_smp carries one beat per audio sample: op process or clear, and the dry sample.
//   o_mix returns one beat (left, right) for each process beat; a clear beat gives none.
//   registers are written through i_cfg_we / i_cfg_idx / i_cfg_data while the block idles;
//   the user must keep to this, as the block itself does not enforce it.
// sharing
//   the serial divider used for the pan angle and the two final scalings, and the single
//   multiplier that every sine term, interpolation and weighting goes through, are each
//   shared by all taps and both channels, one sequencer state at a time.
//   ready is high only in the idle state; one sample is worked on at a time.
// reset and clear
//   reset, and a clear beat, zero the write pointer and fill count and spread the tap
//   phases by a serial division per tap, with ready low meanwhile; store entries not
//   yet written since then read as zero through the fill count.
// stall
//   the result sits in an output register; a new sample is accepted while it waits,
//   and a finished result holds in the sequencer until the register frees.
module multi_tap_chorus_top
    import mtc_pkg::*;
#(
    parameter int DELAY_DEPTH      = 2048,
    parameter int MAX_TAPS         = 8,
    parameter int SINE_TABLE_DEPTH = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    mtc_in_if.sink      i_smp,
    mtc_out_if.source   o_mix
);

    localparam int AW      = $clog2(DELAY_DEPTH);
    localparam int FW      = $clog2(DELAY_DEPTH + 1);
    localparam int TCNT_W  = $clog2(MAX_TAPS + 1);
    localparam int TIDX_W  = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int SIN_L   = $clog2(SINE_TABLE_DEPTH);
    localparam int WACC_W  = 40 + $clog2(MAX_TAPS);
    localparam int DW      = 27;
    localparam int DVC_W   = $clog2(DVD_W + 1);
    localparam logic [DW-2:0] DMAX = (DW-1)'((DELAY_DEPTH - 1) * 256);

    // configuration
    logic [18:0] r_cfg_base;
    logic [18:0] r_cfg_depth;
    logic [31:0] r_cfg_step;
    logic [3:0]  r_cfg_ntaps;
    logic [15:0] r_cfg_mix;
    logic        r_cfg_stereo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_base   <= 19'd5120;
            r_cfg_depth  <= 19'd2048;
            r_cfg_step   <= 32'd1789570;
            r_cfg_ntaps  <= 4'd3;
            r_cfg_mix    <= 16'd16384;
            r_cfg_stereo <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_BASE_DELAY: r_cfg_base   <= i_cfg_data[18:0];
                CFG_DEPTH:      r_cfg_depth  <= i_cfg_data[18:0];
                CFG_PHASE_STEP: r_cfg_step   <= i_cfg_data;
                CFG_NUM_TAPS:   r_cfg_ntaps  <= i_cfg_data[3:0];
                CFG_MIX:        r_cfg_mix    <= i_cfg_data[15:0];
                CFG_STEREO:     r_cfg_stereo <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // clamped tap count and wet fraction
    logic [TCNT_W-1:0] w_n;
    logic [15:0]       w_mix;
    logic [16:0]       w_dry_w;

    always_comb begin
        if (r_cfg_ntaps == 4'd0) begin
            w_n = TCNT_W'(1);
        end else if ({1'b0, r_cfg_ntaps} > 5'(MAX_TAPS)) begin
            w_n = TCNT_W'(MAX_TAPS);
        end else begin
            w_n = TCNT_W'(r_cfg_ntaps);
        end
        w_mix   = (r_cfg_mix > 16'd32768) ? 16'd32768 : r_cfg_mix;
        w_dry_w = Q15_ONE - {1'b0, w_mix};
    end

    // state
    t_state r_state, n_state;
    t_state r_ret;

    logic [15:0]              r_mem [DELAY_DEPTH];
    logic [AW-1:0]            r_wptr;
    logic [FW-1:0]            r_fill;
    logic [31:0]              r_phase [MAX_TAPS];
    logic [TCNT_W-1:0]        r_tap;
    logic                     r_ch;
    logic signed [15:0]       r_dry;

    logic [15:0]              r_sarg;
    logic [15:0]              r_x2;
    logic [16:0]              r_st;
    logic signed [16:0]       r_sres;
    logic [15:0]              r_pan_u;
    logic [AW-1:0]            r_k;
    logic [7:0]               r_f;
    logic signed [24:0]       r_v;
    logic signed [WACC_W-1:0] r_wl, r_wr;
    logic signed [35:0]       r_base;
    logic signed [ACC_W-1:0]  r_acc;

    logic [15:0]              r_rdata;
    logic                     r_rd_ok;

    logic signed [15:0]       r_left, r_right;
    logic signed [15:0]       r_oleft, r_oright;
    logic                     r_ovalid;

    // serial divider
    logic [DVD_W-1:0] r_dv_q;
    logic [DVS_W-2:0] r_dv_rem;
    logic [DVS_W-1:0] r_dv_dvs;
    logic [DVC_W-1:0] r_dv_cnt;
    logic             r_dv_busy;
    logic             w_dv_start;
    logic [DVD_W-1:0] w_dv_dvd;
    logic [DVS_W-1:0] w_dv_dvs;
    logic [DVS_W-1:0] w_dv_trial;
    logic             w_dv_ge;

    assign w_dv_trial = {r_dv_rem, r_dv_q[DVD_W-1]};
    assign w_dv_ge    = (w_dv_trial >= r_dv_dvs);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_busy <= 1'b0;
            r_dv_cnt  <= '0;
        end else if (w_dv_start) begin
            r_dv_busy <= 1'b1;
            r_dv_cnt  <= DVC_W'(DVD_W);
        end else if (r_dv_busy) begin
            r_dv_cnt  <= r_dv_cnt - 1'b1;
            r_dv_busy <= (r_dv_cnt != DVC_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_dv_start) begin
            r_dv_q   <= w_dv_dvd;
            r_dv_rem <= '0;
            r_dv_dvs <= w_dv_dvs;
        end else if (r_dv_busy) begin
            r_dv_q   <= {r_dv_q[DVD_W-2:0], w_dv_ge};
            r_dv_rem <= w_dv_ge ? (DVS_W-1)'(w_dv_trial - r_dv_dvs)
                                : w_dv_trial[DVS_W-2:0];
        end
    end

    // shared multiplier
    logic signed [32:0] n_ma;
    logic signed [19:0] n_mb;
    logic signed [52:0] w_prod;

    assign w_prod = n_ma * n_mb;

    // sine operand: folded quarter-wave position
    logic [15:0] w_x;
    logic [15:0] w_xq;
    assign w_xq = {1'b0, r_sarg[13:0], 1'b0};
    assign w_x  = r_sarg[14] ? (16'd32768 - w_xq) : w_xq;

    logic [16:0] w_y;
    assign w_y = (w_prod[32:15] > 18'd32768) ? Q15_ONE : w_prod[31:15];

    // lfo position: top bits of the phase, as a table index scaled to a 16 bit turn
    logic [15:0] w_lfo_u;
    logic [31:0] w_cur_phase;
    assign w_cur_phase = r_phase[r_tap[TIDX_W-1:0]];
    assign w_lfo_u     = 16'((w_cur_phase >> (32 - SIN_L)) << (16 - SIN_L));

    // delay: base plus depth times sine, clamped into the store
    logic signed [DW-1:0] w_dsum;
    logic [DW-2:0]        w_dcl;
    always_comb begin
        w_dsum = DW'($signed({1'b0, r_cfg_base})) + DW'(w_prod >>> 15);
        if (w_dsum[DW-1]) begin
            w_dcl = '0;
        end else if (w_dsum[DW-2:0] > DMAX) begin
            w_dcl = DMAX;
        end else begin
            w_dcl = w_dsum[DW-2:0];
        end
    end

    // read addresses of the two neighbors
    logic [AW:0]   w_atmp;
    logic [AW-1:0] w_addr_a, w_addr_b, w_rd_addr;
    always_comb begin
        w_atmp = {1'b0, r_wptr} + (AW+1)'(DELAY_DEPTH) - {1'b0, r_k};
        if (w_atmp >= (AW+1)'(DELAY_DEPTH)) begin
            w_atmp = w_atmp - (AW+1)'(DELAY_DEPTH);
        end
        w_addr_a = w_atmp[AW-1:0];
        w_addr_b = (w_addr_a == '0) ? AW'(DELAY_DEPTH - 1) : (w_addr_a - 1'b1);
    end

    logic signed [15:0] w_rd_val;
    assign w_rd_val = r_rd_ok ? $signed(r_rdata) : 16'sd0;

    // final scaling
    logic signed [WACC_W-1:0] w_wsel;
    logic [23:0]              w_mdvd;
    logic signed [19:0]       w_q20;
    logic signed [15:0]       w_sat;
    always_comb begin
        w_wsel = r_ch ? r_wr : r_wl;
        w_mdvd = 24'(r_acc >>> 38) + (24'(w_n) << 17);
        w_q20  = $signed({1'b0, r_dv_q[18:0]}) - 20'sd131072;
        if (w_q20 > 20'sd32767) begin
            w_sat = 16'sd32767;
        end else if (w_q20 < -20'sd32768) begin
            w_sat = -16'sd32768;
        end else begin
            w_sat = w_q20[15:0];
        end
    end

    logic w_accept, w_mem_we, w_load;
    assign i_smp.ready = (r_state == ST_IDLE);
    assign w_accept    = i_smp.valid && (r_state == ST_IDLE);
    assign w_mem_we    = w_accept && (i_smp.op == OP_PROCESS);

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_ma       = '0;
        n_mb       = '0;
        w_dv_start = 1'b0;
        w_dv_dvd   = '0;
        w_dv_dvs   = '0;
        w_rd_addr  = w_addr_a;
        w_load     = 1'b0;
        unique case (r_state)
            ST_INIT: begin
                w_dv_start = 1'b1;
                w_dv_dvd   = DVD_W'(r_tap) << 32;
                w_dv_dvs   = DVS_W'(w_n);
                n_state    = ST_IWAIT;
            end
            ST_IWAIT: begin
                if (!r_dv_busy) begin
                    n_state = (TCNT_W'(r_tap + 1'b1) == TCNT_W'(MAX_TAPS)) ? ST_IDLE : ST_INIT;
                end
            end
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = (i_smp.op == OP_CLEAR) ? ST_INIT : ST_TAP;
                end
            end
            ST_TAP: n_state = ST_SIN_A;
            ST_SIN_A: begin
                n_ma    = $signed(33'(w_x));
                n_mb    = $signed(20'(w_x));
                n_state = ST_SIN_B;
            end
            ST_SIN_B: begin
                n_ma    = $signed(SIN_C);
                n_mb    = $signed(20'(r_x2));
                n_state = ST_SIN_C;
            end
            ST_SIN_C: begin
                n_ma    = $signed(33'(r_st));
                n_mb    = $signed(20'(r_x2));
                n_state = ST_SIN_D;
            end
            ST_SIN_D: begin
                n_ma    = $signed(33'(r_st));
                n_mb    = $signed(20'(w_x));
                n_state = r_ret;
            end
            ST_DLY: begin
                n_ma    = $signed(33'(r_cfg_depth));
                n_mb    = 20'(r_sres);
                n_state = ST_RDA;
            end
            ST_RDA: begin
                w_rd_addr = w_addr_a;
                n_state   = ST_RDB;
            end
            ST_RDB: begin
                w_rd_addr = w_addr_b;
                n_ma      = 33'(w_rd_val);
                n_mb      = $signed(20'(9'd256 - {1'b0, r_f}));
                n_state   = ST_MB;
            end
            ST_MB: begin
                n_ma    = 33'(w_rd_val);
                n_mb    = $signed(20'(r_f));
                n_state = ST_PAN;
            end
            ST_PAN: begin
                priority if (!r_cfg_stereo) begin
                    n_state = ST_MONO;
                end else if (w_n > TCNT_W'(1)) begin
                    w_dv_start = 1'b1;
                    w_dv_dvd   = DVD_W'(r_tap) << 14;
                    w_dv_dvs   = DVS_W'(w_n - 1'b1);
                    n_state    = ST_PDIV;
                end else begin
                    n_state = ST_SIN_A;
                end
            end
            ST_PDIV: begin
                if (!r_dv_busy) begin
                    n_state = ST_SIN_A;
                end
            end
            ST_PL: begin
                n_ma    = 33'(r_v);
                n_mb    = 20'(r_sres);
                n_state = ST_SIN_A;
            end
            ST_PR: begin
                n_ma    = 33'(r_v);
                n_mb    = 20'(r_sres);
                n_state = ST_NEXT;
            end
            ST_MONO: n_state = ST_NEXT;
            ST_NEXT: begin
                n_state = (TCNT_W'(r_tap + 1'b1) < w_n) ? ST_TAP : ST_ADV;
            end
            ST_ADV: n_state = ST_MX1;
            ST_MX1: begin
                n_ma    = 33'(r_dry);
                n_mb    = $signed(20'(w_dry_w));
                n_state = ST_MX2;
            end
            ST_MX2: begin
                n_ma    = 33'(r_base);
                n_mb    = $signed(20'(w_n));
                n_state = ST_CH1;
            end
            ST_CH1: begin
                n_ma    = $signed(33'(w_wsel[21:0]));
                n_mb    = $signed(20'(w_mix));
                n_state = ST_CH2;
            end
            ST_CH2: begin
                n_ma    = 33'(w_wsel >>> 22);
                n_mb    = $signed(20'(w_mix));
                n_state = ST_CH3;
            end
            ST_CH3: begin
                w_dv_start = 1'b1;
                w_dv_dvd   = DVD_W'(w_mdvd);
                w_dv_dvs   = DVS_W'(w_n);
                n_state    = ST_CH4;
            end
            ST_CH4: begin
                if (!r_dv_busy) begin
                    n_state = r_ch ? ST_DONE : ST_CH1;
                end
            end
            ST_DONE: begin
                if (!r_ovalid || o_mix.ready) begin
                    w_load  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // store write and registered read; entries past the fill count read as zero
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[r_wptr] <= i_smp.sample_in;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[w_rd_addr];
        r_rd_ok <= (FW'(w_rd_addr) < r_fill);
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_fill <= '0;
            r_tap  <= '0;
            r_ch   <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IWAIT: begin
                    if (!r_dv_busy) begin
                        r_tap <= r_tap + 1'b1;
                    end
                end
                ST_IDLE: begin
                    if (w_accept) begin
                        r_tap <= '0;
                        r_ch  <= 1'b0;
                        if (i_smp.op == OP_CLEAR) begin
                            r_wptr <= '0;
                            r_fill <= '0;
                        end else if (r_fill != FW'(DELAY_DEPTH)) begin
                            r_fill <= r_fill + 1'b1;
                        end
                    end
                end
                ST_NEXT: r_tap <= r_tap + 1'b1;
                ST_ADV: begin
                    r_wptr <= (r_wptr == AW'(DELAY_DEPTH - 1)) ? '0 : (r_wptr + 1'b1);
                end
                ST_CH4: begin
                    if (!r_dv_busy) begin
                        r_ch <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IWAIT: begin
                if (!r_dv_busy) begin
                    r_phase[r_tap[TIDX_W-1:0]] <= r_dv_q[31:0];
                end
            end
            ST_IDLE: begin
                r_dry <= i_smp.sample_in;
                r_wl  <= '0;
                r_wr  <= '0;
            end
            ST_TAP: begin
                r_sarg <= w_lfo_u;
                r_ret  <= ST_DLY;
            end
            ST_SIN_A: r_x2 <= w_prod[30:15];
            ST_SIN_B: r_st <= SIN_B - w_prod[31:15];
            ST_SIN_C: r_st <= SIN_A - w_prod[31:15];
            ST_SIN_D: r_sres <= r_sarg[15] ? -$signed(w_y) : $signed(w_y);
            ST_DLY: begin
                r_k <= w_dcl[AW+7:8];
                r_f <= w_dcl[7:0];
            end
            ST_RDB: r_v <= 25'(w_prod);
            ST_MB:  r_v <= r_v + 25'(w_prod);
            ST_PAN: begin
                // single stereo tap sits at the center of the pan law
                r_pan_u <= 16'd8192;
                r_sarg  <= 16'd24576;
                r_ret   <= ST_PL;
            end
            ST_PDIV: begin
                r_pan_u <= r_dv_q[15:0];
                r_sarg  <= r_dv_q[15:0] + 16'd16384;
                r_ret   <= ST_PL;
            end
            ST_PL: begin
                r_wl   <= r_wl + WACC_W'(w_prod);
                r_sarg <= r_pan_u;
                r_ret  <= ST_PR;
            end
            ST_PR:   r_wr <= r_wr + WACC_W'(w_prod);
            ST_MONO: begin
                r_wl <= r_wl + (WACC_W'(r_v) <<< 15);
                r_wr <= r_wr + (WACC_W'(r_v) <<< 15);
            end
            ST_ADV: begin
                for (int i = 0; i < MAX_TAPS; i++) begin
                    r_phase[i] <= r_phase[i] + r_cfg_step;
                end
            end
            ST_MX1: r_base <= 36'(w_prod);
            ST_MX2: r_base <= 36'(w_prod);
            ST_CH1: begin
                // dry term, low part of the wet term and the rounding half
                r_acc <= (ACC_W'(r_base) <<< 23) + ACC_W'(w_prod)
                         + $signed(ACC_W'(w_n) << 37);
            end
            ST_CH2: r_acc <= r_acc + (ACC_W'(w_prod) <<< 22);
            ST_CH4: begin
                if (!r_dv_busy) begin
                    if (r_ch) begin
                        r_right <= w_sat;
                    end else begin
                        r_left <= w_sat;
                    end
                end
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_load) begin
            r_ovalid <= 1'b1;
        end else if (o_mix.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_oleft  <= r_left;
            r_oright <= r_right;
        end
    end

    assign o_mix.valid     = r_ovalid;
    assign o_mix.left_out  = r_oleft;
    assign o_mix.right_out = r_oright;

    // checks
    a_div_idle_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_dv_start |-> !r_dv_busy)
        else $error("divider started while busy");

    // the pointer moves after the taps of a sample, so the two are compared only between samples
    a_fill_tracks_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && r_fill < FW'(DELAY_DEPTH)) |-> (FW'(r_wptr) == r_fill))
        else $error("fill count and write pointer disagree");

    a_clear_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_smp.op == OP_CLEAR) |=> (r_state == ST_INIT && r_wptr == '0))
        else $error("clear beat did not restart the store");

    a_tap_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DLY) |-> (r_tap < w_n))
        else $error("tap counter beyond active taps");

endmodule

// File: tb/mtc_scoreboard.sv
// scoreboard: chorus predictor and queue of expected mixed beats
`timescale 1ns / 1ps
class mtc_scoreboard;
    localparam int DEPTH = 2048;
    localparam int TAPS  = 8;
    localparam int SINE_DEPTH = 1024;

    logic [18:0] base_q8, depth_q8;
    logic [31:0] step;
    logic [3:0]  ntaps;
    logic [15:0] mix;
    logic        stereo;
    logic signed [15:0] store [DEPTH];
    int unsigned wptr;
    logic [31:0] phase [TAPS];
    logic signed [15:0] exp_left [$];
    logic signed [15:0] exp_right [$];
    int errors;
    int checked;

    function new();
        errors = 0;
        checked = 0;
        power_on();
    endfunction

    function void power_on();
        base_q8 = 19'd5120;
        depth_q8 = 19'd2048;
        step = 32'd1789570;
        ntaps = 4'd3;
        mix = 16'd16384;
        stereo = 1'b1;
        clear();
    endfunction

    function int unsigned taps_active();
        if (ntaps < 1) return 1;
        if (ntaps > TAPS) return TAPS;
        return ntaps;
    endfunction

    function void clear();
        int unsigned n;
        n = taps_active();
        for (int i = 0; i < DEPTH; i++) store[i] = '0;
        wptr = 0;
        for (int t = 0; t < TAPS; t++) phase[t] = 32'((64'(t) << 32) / n);
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] data);
        case (idx)
            mtc_pkg::CFG_BASE_DELAY: base_q8 = data[18:0];
            mtc_pkg::CFG_DEPTH:      depth_q8 = data[18:0];
            mtc_pkg::CFG_PHASE_STEP: step = data;
            mtc_pkg::CFG_NUM_TAPS:   ntaps = data[3:0];
            mtc_pkg::CFG_MIX:        mix = data[15:0];
            mtc_pkg::CFG_STEREO:     stereo = data[0];
            default: ;
        endcase
    endfunction

    // quarter wave polynomial, q15 result in [-32768, 32768]
    function longint sine_q15(logic [31:0] turn);
        logic [15:0] u;
        logic [1:0]  quad;
        longint x, x2, p, y;
        u = turn[15:0];
        quad = u[15:14];
        x = longint'(u[13:0]) << 1;
        if (quad[0]) x = 32768 - x;
        x2 = (x * x) >>> 15;
        p = (2320 * x2) >>> 15;
        p = 21024 - p;
        p = (p * x2) >>> 15;
        p = 51472 - p;
        y = (p * x) >>> 15;
        if (y > 32768) y = 32768;
        return quad[1] ? -y : y;
    endfunction

    function longint div_floor(longint num, longint den);
        if (num >= 0) return num / den;
        return -((-num + den - 1) / den);
    endfunction

    function longint clip16(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    // note an accepted input beat
    function void note_input(logic op, logic signed [15:0] smp);
        int unsigned n, w, k, f, ang;
        longint s, d, a, b, v, pl, pr, wl, wr, den, dry_part, m, idx;
        if (op == mtc_pkg::OP_CLEAR) begin
            clear();
            return;
        end
        n = taps_active();
        m = (mix > 16'd32768) ? 32768 : longint'(mix);
        w = wptr;
        store[w] = smp;
        wl = 0;
        wr = 0;
        for (int unsigned t = 0; t < n; t++) begin
            idx = (longint'(phase[t]) * SINE_DEPTH) >>> 32;
            s = sine_q15(32'((idx * 65536) / SINE_DEPTH));
            d = longint'(base_q8) + div_floor(longint'(depth_q8) * s, 32768);
            if (d < 0) d = 0;
            if (d > (DEPTH - 1) * 256) d = (DEPTH - 1) * 256;
            k = int'(d >>> 8);
            f = int'(d & 255);
            a = store[(w + DEPTH - k) % DEPTH];
            b = store[(w + 2 * DEPTH - k - 1) % DEPTH];
            v = a * (256 - f) + b * f;
            if (stereo) begin
                ang = (n > 1) ? (t * 16384) / (n - 1) : 8192;
                pl = sine_q15(ang + 16384);
                pr = sine_q15(ang);
            end else begin
                pl = 32768;
                pr = 32768;
            end
            wl += v * pl;
            wr += v * pr;
        end
        for (int t = 0; t < TAPS; t++) phase[t] += step;
        wptr = (w + 1) % DEPTH;
        den = longint'(n) << 38;
        dry_part = longint'(smp) * (32768 - m) * n * (longint'(1) << 23);
        exp_left.push_back(16'(clip16(div_floor(dry_part + wl * m + den / 2, den))));
        exp_right.push_back(16'(clip16(div_floor(dry_part + wr * m + den / 2, den))));
    endfunction

    function void report(string what);
        errors++;
        $display("mismatch: %s", what);
    endfunction

    // compare an accepted output beat with the oldest expectation
    function void check_output(logic signed [15:0] l, logic signed [15:0] r);
        logic signed [15:0] el, er;
        checked++;
        if (exp_left.size() == 0) begin
            report($sformatf("unexpected beat left %0d right %0d", l, r));
            return;
        end
        el = exp_left.pop_front();
        er = exp_right.pop_front();
        if (l !== el) report($sformatf("beat %0d left %0d want %0d", checked, l, el));
        if (r !== er) report($sformatf("beat %0d right %0d want %0d", checked, r, er));
    endfunction

    function int pending();
        return exp_left.size();
    endfunction
endclass

// File: tb/multi_tap_chorus_top_test.sv
// testbench top: drives the chorus with directed and random beats and checks its mixes
`timescale 1ns / 1ps
module multi_tap_chorus_top_test;
    import mtc_pkg::*;

    localparam int RANDOM_BEATS = 1150;
    localparam int WATCHDOG = 200000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [31:0] i_cfg_data;

    mtc_in_if  smp_if ();
    mtc_out_if mix_if ();

    multi_tap_chorus_top i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_smp      (smp_if.sink),
        .o_mix      (mix_if.source)
    );

    mtc_scoreboard chorus_sb;
    int  idle_cycles;
    int  hold_off;      // cycles the receiver still holds off, counted by the sink process
    bit  sink_fast;     // stretch with no stalls on the output side
    int  sent;
    int  clears;

    // 2 ns clock
    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 4);
        return $urandom_range(20, 300);
    endfunction

    // output side: random stalls, forced hold-off when asked; sampling at the rising edge
    initial begin
        int gap;
        mix_if.ready = 1'b0;
        hold_off = 0;
        sink_fast = 1'b0;
        gap = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && mix_if.valid && mix_if.ready)
                chorus_sb.check_output(mix_if.left_out, mix_if.right_out);
            @(negedge i_clk);
            if (hold_off > 0) begin
                hold_off--;
                mix_if.ready <= 1'b0;
            end else if (sink_fast) begin
                mix_if.ready <= 1'b1;
            end else if (gap > 0) begin
                gap--;
                mix_if.ready <= 1'b0;
            end else begin
                mix_if.ready <= 1'b1;
                if ($urandom_range(0, 3) == 0) gap = gap_len();
            end
        end
    end

    // note accepted input beats at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && smp_if.valid && smp_if.ready)
            chorus_sb.note_input(smp_if.op, smp_if.sample_in);
    end

    // watchdog on cycles with no accepted beat
    always @(posedge i_clk) begin
        if ((smp_if.valid && smp_if.ready) || (mix_if.valid && mix_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG) begin
            $display("watchdog expired with %0d beats outstanding", chorus_sb.pending());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // offer one beat and hold it until accepted
    task automatic send_beat(logic op, logic signed [15:0] smp, bit with_gap);
        int g;
        if (with_gap) begin
            g = gap_len();
            repeat (g) @(negedge i_clk);
        end
        @(negedge i_clk);
        smp_if.valid <= 1'b1;
        smp_if.op <= op;
        smp_if.sample_in <= smp;
        do @(posedge i_clk); while (!smp_if.ready);
        @(negedge i_clk);
        smp_if.valid <= 1'b0;
        smp_if.op <= 1'($urandom_range(0, 1));
        smp_if.sample_in <= 16'($urandom);
        if (op == OP_CLEAR) clears++;
        else sent++;
    endtask

    // back-to-back beats keep valid high between them
    task automatic send_burst(int count);
        @(negedge i_clk);
        for (int i = 0; i < count; i++) begin
            smp_if.valid <= 1'b1;
            smp_if.op <= OP_PROCESS;
            smp_if.sample_in <= 16'($urandom);
            do @(posedge i_clk); while (!smp_if.ready);
            @(negedge i_clk);
            sent++;
        end
        smp_if.valid <= 1'b0;
    endtask

    // wait until every expected mix is back, then let a clear finish inside the block
    task automatic drain();
        while (chorus_sb.pending() != 0) @(negedge i_clk);
        repeat (400) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        chorus_sb.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // one configuration setting for a phase of the run
    task automatic configure(logic [18:0] base, logic [18:0] dep, logic [31:0] stp,
                             logic [3:0] taps, logic [15:0] m, logic st);
        drain();
        write_reg(CFG_BASE_DELAY, {13'd0, base});
        write_reg(CFG_DEPTH, {13'd0, dep});
        write_reg(CFG_PHASE_STEP, stp);
        write_reg(CFG_NUM_TAPS, {28'd0, taps});
        write_reg(CFG_MIX, {16'd0, m});
        write_reg(CFG_STEREO, {31'd0, st});
    endtask

    // random musical-ish sample: full range, extremes, or small values
    function automatic logic signed [15:0] pick_sample();
        case ($urandom_range(0, 5))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return 16'($signed($urandom_range(0, 255)) - 128);
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        chorus_sb = new();
        idle_cycles = 0;
        sent = 0;
        clears = 0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        smp_if.valid = 1'b0;
        smp_if.op = OP_PROCESS;
        smp_if.sample_in = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset values, extreme samples, clear op
        send_beat(OP_PROCESS, 16'sh7fff, 1'b0);
        send_beat(OP_PROCESS, 16'sh8000, 1'b0);
        send_beat(OP_PROCESS, 16'sh0000, 1'b0);
        send_beat(OP_PROCESS, 16'shffff, 1'b0);
        send_beat(OP_PROCESS, 16'sh5555, 1'b0);
        send_beat(OP_PROCESS, 16'shaaaa, 1'b0);
        send_beat(OP_CLEAR, 16'sh1234, 1'b0);
        send_beat(OP_PROCESS, 16'sh4000, 1'b0);
        // tap count zero acts as one, mix above full acts as full wet
        configure(19'd256, 19'd0, 32'd0, 4'd0, 16'hffff, 1'b1);
        send_beat(OP_PROCESS, 16'sh7fff, 1'b0);
        send_beat(OP_PROCESS, 16'sh8000, 1'b0);
        send_beat(OP_PROCESS, 16'sh0100, 1'b0);
        // more taps than exist, delay past the store end, mono
        configure(19'h7ffff, 19'h7ffff, 32'hffffffff, 4'd15, 16'd32768, 1'b0);
        send_beat(OP_CLEAR, 16'sh0000, 1'b0);
        send_beat(OP_PROCESS, 16'sh7fff, 1'b0);
        send_beat(OP_PROCESS, 16'sh8000, 1'b0);
        // tap count change without re-spread, dry only
        configure(19'd256, 19'h7ffff, 32'h40000000, 4'd8, 16'd0, 1'b1);
        send_beat(OP_PROCESS, 16'sh7fff, 1'b0);
        send_beat(OP_PROCESS, 16'sh8000, 1'b0);
        send_beat(OP_CLEAR, 16'sh0000, 1'b0);
        send_beat(OP_PROCESS, 16'sh1000, 1'b0);

        // receiver holds off while the sender keeps offering
        hold_off = 3000;
        send_burst(6);

        // random phases under several settings
        for (int ph = 0; ph < 10; ph++) begin
            int beats;
            logic [3:0] taps;
            taps = (ph % 3 == 0) ? 4'($urandom_range(1, 8)) : 4'($urandom_range(0, 15));
            configure(19'($urandom_range(256, 524287) % (ph < 5 ? 8192 : 524288)),
                      19'($urandom_range(0, 524287) % (ph < 5 ? 4096 : 524288)),
                      $urandom, taps, 16'($urandom_range(0, 40000)), 1'($urandom));
            sink_fast = (ph == 4);
            if ($urandom_range(0, 1)) send_beat(OP_CLEAR, 16'($urandom), 1'b0);
            beats = RANDOM_BEATS / 10;
            for (int i = 0; i < beats; i++) begin
                if ($urandom_range(0, 39) == 0)
                    send_beat(OP_CLEAR, 16'($urandom), 1'b1);
                else if (ph == 7 && $urandom_range(0, 3) == 0)
                    send_burst($urandom_range(2, 6));
                else
                    send_beat(OP_PROCESS, pick_sample(), ph != 4);
                // halfway through phase 2 the sender pauses until every expected beat is back
                if (i == beats / 2 && ph == 2)
                    while (chorus_sb.pending() != 0) @(negedge i_clk);
            end
        end
        sink_fast = 1'b0;

        while (chorus_sb.pending() != 0) @(negedge i_clk);
        repeat (2000) @(negedge i_clk);
        $display("covered %0d samples and %0d clears over 14 register settings,",
                 sent, clears);
        $display("with tap counts 0..15, mono and stereo, and full stalls on both sides");
        if (chorus_sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
